### rtl/dsb64_pkg.sv
// ----------------------------------------------------------------------------
// dsb64_pkg
// Shared types and alphabet lookups for the DNS-safe base64 codec.
// ----------------------------------------------------------------------------
package dsb64_pkg;

  localparam int SymW  = 6;
  localparam int ByteW = 8;
  localparam int AccW  = 12;
  localparam int CntW  = 3;

  // One result beat
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             has_data;
    logic             eom;
    logic             stop;
  } res_t;

  // Results of one processed item, handed to the output queue
  typedef struct packed {
    logic       valid;
    logic [1:0] num;
    res_t       res0;
    res_t       res1;
  } push_t;

  // Symbol value to character: digits, lower case, upper case, '_', '-'
  function automatic logic [ByteW-1:0] sym_to_char(input logic [SymW-1:0] s);
    logic [ByteW-1:0] sx;
    sx = {2'b00, s};
    case (s) inside
      [6'd0:6'd9]:   return 8'h30 + sx;
      [6'd10:6'd35]: return 8'h57 + sx;
      [6'd36:6'd61]: return 8'h1D + sx;
      6'd62:         return 8'h5F;
      default:       return 8'h2D;
    endcase
  endfunction

  // Character to {valid, symbol value}
  function automatic logic [SymW:0] char_to_sym(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] d;
    logic [ByteW-1:0] l;
    logic [ByteW-1:0] u;
    d = c - 8'h30;
    l = c - 8'h57;
    u = c - 8'h1D;
    case (c) inside
      [8'h30:8'h39]: return {1'b1, d[SymW-1:0]};
      [8'h61:8'h7A]: return {1'b1, l[SymW-1:0]};
      [8'h41:8'h5A]: return {1'b1, u[SymW-1:0]};
      8'h5F:         return {1'b1, 6'd62};
      8'h2D:         return {1'b1, 6'd63};
      default:       return {1'b0, 6'd0};
    endcase
  endfunction

endpackage

### rtl/dsb64_core.sv
// ----------------------------------------------------------------------------
// dsb64_core
// Input register, codec state and the single-pass encode/decode step.
// ----------------------------------------------------------------------------
module dsb64_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                in_tlast,
  input  logic                space,
  output dsb64_pkg::push_t    push
);
  import dsb64_pkg::*;

  logic             dir_r;
  logic             in_vld_r, in_vld_nxt;
  logic [ByteW-1:0] in_byte_r;
  logic             in_last_r;
  logic [AccW-1:0]  acc_r, acc_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             halt_r, halt_nxt;

  logic             proc;
  logic             accept;
  logic [AccW-1:0]  enc_acc;
  logic [AccW-1:0]  dec_acc;
  logic [SymW:0]    sym;
  push_t            step;

  assign proc      = in_vld_r & space;
  assign in_tready = ~in_vld_r | proc;
  assign accept    = in_tvalid & in_tready;

  assign enc_acc = {acc_r[3:0], in_byte_r};
  assign dec_acc = {acc_r[5:0], sym[SymW-1:0]};
  assign sym     = char_to_sym(in_byte_r);

  always_comb begin
    step     = '0;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    halt_nxt = halt_r;
    if (!dir_r) begin
      // encode: always at least one character
      step.res0.has_data = 1'b1;
      step.res1.has_data = 1'b1;
      acc_nxt            = enc_acc;
      case (cnt_r)
        3'd2: begin
          step.res0.data = sym_to_char(enc_acc[9:4]);
          step.res1.data = sym_to_char({enc_acc[3:0], 2'b00});
          step.num       = in_last_r ? 2'd2 : 2'd1;
          cnt_nxt        = 3'd4;
        end
        3'd4: begin
          step.res0.data = sym_to_char(enc_acc[11:6]);
          step.res1.data = sym_to_char(enc_acc[5:0]);
          step.num       = 2'd2;
          cnt_nxt        = 3'd0;
        end
        default: begin
          step.res0.data = sym_to_char(enc_acc[7:2]);
          step.res1.data = sym_to_char({enc_acc[1:0], 4'b0000});
          step.num       = in_last_r ? 2'd2 : 2'd1;
          cnt_nxt        = 3'd2;
        end
      endcase
      if (step.num == 2'd2) begin
        step.res1.eom = in_last_r;
      end else begin
        step.res0.eom = in_last_r;
      end
    end else begin
      if (!halt_r && !sym[SymW]) begin
        halt_nxt = 1'b1;
      end
      if (!halt_r && sym[SymW]) begin
        acc_nxt = dec_acc;
        case (cnt_r)
          3'd2: begin
            step.res0.data     = dec_acc[7:0];
            step.res0.has_data = 1'b1;
            cnt_nxt            = 3'd0;
          end
          3'd4: begin
            step.res0.data     = dec_acc[9:2];
            step.res0.has_data = 1'b1;
            cnt_nxt            = 3'd2;
          end
          3'd6: begin
            step.res0.data     = dec_acc[11:4];
            step.res0.has_data = 1'b1;
            cnt_nxt            = 3'd4;
          end
          default: begin
            cnt_nxt = 3'd6;
          end
        endcase
      end
      // bare end marker carries the halt flag
      step.res0.eom  = in_last_r;
      step.res0.stop = ~step.res0.has_data & halt_nxt;
      step.num       = (step.res0.has_data | in_last_r) ? 2'd1 : 2'd0;
    end
    if (in_last_r) begin
      acc_nxt  = '0;
      cnt_nxt  = '0;
      halt_nxt = 1'b0;
    end
    step.valid = proc;
  end

  assign push = step;

  assign in_vld_nxt = accept | (in_vld_r & ~proc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r    <= 1'b0;
      in_vld_r <= 1'b0;
      acc_r    <= '0;
      cnt_r    <= '0;
      halt_r   <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
      if (cfg_wr_en) begin
        // direction change discards any partial message
        dir_r  <= cfg_wr_data;
        acc_r  <= '0;
        cnt_r  <= '0;
        halt_r <= 1'b0;
      end else if (proc) begin
        acc_r  <= acc_nxt;
        cnt_r  <= cnt_nxt;
        halt_r <= halt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

endmodule

### rtl/dsb64_outq.sv
// ----------------------------------------------------------------------------
// dsb64_outq
// Two-entry result queue; takes up to two results of one item at once.
// ----------------------------------------------------------------------------
module dsb64_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  dsb64_pkg::push_t  push,
  output logic              space,
  output logic              out_vld,
  input  logic              out_rdy,
  output dsb64_pkg::res_t   out_res
);
  import dsb64_pkg::*;

  logic [1:0] cnt_r, cnt_nxt;
  res_t       q0_r, q0_nxt;
  res_t       q1_r, q1_nxt;
  logic       pop;

  assign out_vld = (cnt_r != 2'd0);
  assign out_res = q0_r;
  assign pop     = out_vld & out_rdy;
  // empty once this cycle's beat leaves
  assign space   = (cnt_r == 2'd0) | ((cnt_r == 2'd1) & out_rdy);

  always_comb begin
    cnt_nxt = cnt_r;
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    if (push.valid) begin
      cnt_nxt = push.num;
      q0_nxt  = push.res0;
      q1_nxt  = push.res1;
    end else if (pop) begin
      cnt_nxt = cnt_r - 2'd1;
      q0_nxt  = q1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

endmodule

### rtl/dns_safe_base64_codec.sv
// ----------------------------------------------------------------------------
// dns_safe_base64_codec
// Streaming base64 codec, DNS-safe alphabet, no padding characters.
// ----------------------------------------------------------------------------
// Encode (direction 0) turns bytes into characters of the alphabet 0-9 a-z A-Z
// '_' '-', zero-filling a partial group into one final character on the last
// byte; decode (direction 1) turns characters back into bytes and halts at the
// first character outside the alphabet until the end of the message. Each
// input beat is registered, processed in a single pass, and its one or two
// results go into a two-entry output queue; a new beat is taken once the
// queue will be empty, so beats giving one result (and decode generally)
// flow at one per cycle while out_tready is high; an encode beat giving two
// characters holds the next beat until its first has left the result port.
// Write direction only while idle; a write also clears any partial message.
module dns_safe_base64_codec (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,   // direction: 0 encode, 1 decode
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,      // [7:0] in_byte
  input  logic       in_tlast,      // is_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,     // [7:0] out_byte
  output logic [1:0] out_tuser,     // [0] has_data, [1] stopped_early
  output logic       out_tlast      // end_of_message
);
  import dsb64_pkg::*;

  push_t push;
  res_t  head;
  logic  space;

  dsb64_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .space       (space),
    .push        (push)
  );

  dsb64_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .space   (space),
    .out_vld (out_tvalid),
    .out_rdy (out_tready),
    .out_res (head)
  );

  assign out_tdata = head.data;
  assign out_tuser = {head.stop, head.has_data};
  assign out_tlast = head.eom;

endmodule

### rtl/dsb64_checker.sv
// ----------------------------------------------------------------------------
// dsb64_checker
// Port-level checks for the codec, bound to the top level.
// ----------------------------------------------------------------------------
module dsb64_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // a beat without data is only ever the end marker
  a_bare_is_eom: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast && out_tdata == 8'h00)
    else $error("bare beat not a clean end marker");

  // the halt flag rides only on a bare end marker
  a_stop_bare: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tuser[0] && out_tlast)
    else $error("stopped_early on a data beat");

  // nothing leaves in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

endmodule

bind dns_safe_base64_codec dsb64_checker u_dsb64_checker (.*);
